[hw/rtl/lzss_stream_decompressor_top_defines.svh]
// Assertion macros shared by the decompressor RTL.
`ifndef LZSS_STREAM_DECOMPRESSOR_TOP_DEFINES_SVH
`define LZSS_STREAM_DECOMPRESSOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LZSSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LZSSD_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LZSSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LZSSD_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/lzssd_pkg.sv]
`timescale 1ns / 1ps
package lzssd_pkg;

    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int MAX_RUN          = 18;
    localparam int MIN_RUN          = 3;
    localparam int BYTE_W           = 8;
    localparam int OLEN_W           = 31;
    localparam int CNT_W            = 32;
    localparam int DIST_W           = 12;
    localparam int LEN_W            = $clog2(MAX_RUN + 1);
    localparam int FLAGS_PER_BYTE   = 8;
    localparam int FIDX_W           = $clog2(FLAGS_PER_BYTE);
    localparam int SUM_BYTES        = 4;
    localparam int SEEN_W           = $clog2(SUM_BYTES);
    localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;

    typedef enum logic [2:0] {
        PH_FLAG,
        PH_PACKET,
        PH_PTR_HIGH,
        PH_SUM,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LIT,
        OP_RUN,
        OP_VERDICT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              clear;
        logic [BYTE_W-1:0] data;
        logic [DIST_W-1:0] distance;
        logic [LEN_W-1:0]  len;
        logic              ok;
    } t_cmd;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] sum;
    } t_emit_status;

endpackage

[hw/rtl/lzssd_ram.sv]
`timescale 1ns / 1ps
module lzssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/lzssd_ctrl.sv]
`timescale 1ns / 1ps
`include "lzss_stream_decompressor_top_defines.svh"
module lzssd_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [lzssd_pkg::OLEN_W-1:0] i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lzssd_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_start,
    input  lzssd_pkg::t_emit_status     i_status,
    output logic                        o_cmd_valid,
    output lzssd_pkg::t_cmd             o_cmd
);
    import lzssd_pkg::*;

    logic [OLEN_W-1:0] r_olen;
    t_phase            r_phase, n_phase, e_phase, base_phase;
    logic [BYTE_W-1:0] r_flags, n_flags;
    logic [FIDX_W-1:0] r_fidx, n_fidx;
    logic [BYTE_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_stored, n_stored;
    logic [SEEN_W-1:0] r_seen, n_seen;

    logic              accept;
    logic [CNT_W-1:0]  cnt_now;
    logic [CNT_W-1:0]  stored_now;
    logic [SEEN_W-1:0] seen_now;
    logic [CNT_W-1:0]  stored_calc;
    logic              lit_bit;
    logic              last_packet;
    logic [LEN_W-1:0]  len_full;
    t_cmd              cmd;

    assign o_ready     = i_status.idle;
    assign accept      = i_valid && i_status.idle;
    assign cnt_now     = i_start ? '0 : i_status.count;
    assign stored_now  = i_start ? '0 : r_stored;
    assign seen_now    = i_start ? '0 : r_seen;
    assign lit_bit     = r_flags[r_fidx];
    assign last_packet = (r_fidx == FIDX_W'(FLAGS_PER_BYTE - 1));
    assign stored_calc = stored_now | (CNT_W'(i_byte) << {seen_now, 3'b000});
    assign len_full    = LEN_W'(i_byte[3:0]) + LEN_W'(MIN_RUN);

    always_comb begin
        base_phase = i_start ? PH_FLAG : r_phase;
        e_phase    = base_phase;
        if ((base_phase == PH_FLAG || base_phase == PH_PACKET) &&
            cnt_now >= CNT_W'(r_olen)) begin
            e_phase = PH_SUM;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (e_phase)
                PH_FLAG:     n_phase = PH_PACKET;
                PH_PACKET: begin
                    if (!lit_bit) begin
                        n_phase = PH_PTR_HIGH;
                    end else begin
                        n_phase = last_packet ? PH_FLAG : PH_PACKET;
                    end
                end
                PH_PTR_HIGH: n_phase = last_packet ? PH_FLAG : PH_PACKET;
                PH_SUM:      n_phase = (seen_now == SEEN_W'(SUM_BYTES - 1)) ? PH_DONE : PH_SUM;
                PH_DONE:     n_phase = PH_DONE;
                default:     n_phase = PH_FLAG;
            endcase
        end
    end

    // outputs and datapath
    always_comb begin
        n_flags   = r_flags;
        n_fidx    = r_fidx;
        n_ptr     = r_ptr;
        n_stored  = stored_now;
        n_seen    = seen_now;
        cmd       = '0;
        cmd.op    = OP_NONE;
        cmd.clear = i_start;
        case (e_phase)
            PH_FLAG: begin
                n_flags = i_byte;
                n_fidx  = '0;
            end
            PH_PACKET: begin
                if (lit_bit) begin
                    cmd.op   = OP_LIT;
                    cmd.data = i_byte;
                    n_fidx   = r_fidx + 1'b1;
                end else begin
                    n_ptr = i_byte;
                end
            end
            PH_PTR_HIGH: begin
                cmd.op       = OP_RUN;
                cmd.distance = {i_byte[7:4], r_ptr};
                cmd.len      = (len_full > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN) : len_full;
                n_fidx       = r_fidx + 1'b1;
            end
            PH_SUM: begin
                n_stored = stored_calc;
                n_seen   = seen_now + 1'b1;
                if (seen_now == SEEN_W'(SUM_BYTES - 1)) begin
                    cmd.op = OP_VERDICT;
                    cmd.ok = (stored_calc == i_status.sum);
                end
            end
            PH_DONE: begin
                cmd.op = OP_NONE;
            end
            default: begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    assign o_cmd_valid = accept;
    assign o_cmd       = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_olen   <= '0;
            r_phase  <= PH_FLAG;
            r_flags  <= '0;
            r_fidx   <= '0;
            r_ptr    <= '0;
            r_stored <= '0;
            r_seen   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_olen <= i_cfg_wr_data;
            end
            r_phase <= n_phase;
            if (accept) begin
                r_flags  <= n_flags;
                r_fidx   <= n_fidx;
                r_ptr    <= n_ptr;
                r_stored <= n_stored;
                r_seen   <= n_seen;
            end
        end
    end

    `LZSSD_ASSERT(a_done_silent, i_clk, i_rst_n,
        (accept && !i_start && r_phase == PH_DONE) |-> (cmd.op == OP_NONE),
        "byte after verdict produced output")
    `LZSSD_ASSERT(a_run_only_ptr, i_clk, i_rst_n,
        (accept && cmd.op == OP_RUN) |-> (r_phase == PH_PTR_HIGH && !i_start),
        "run issued outside pointer high byte")
    `LZSSD_ASSERT_NR(a_reset_phase, i_clk,
        !i_rst_n |=> (r_phase == PH_FLAG && r_seen == '0),
        "reset did not clear parser")
endmodule

[hw/rtl/lzssd_emit.sv]
`timescale 1ns / 1ps
`include "lzss_stream_decompressor_top_defines.svh"
module lzssd_emit #(
    parameter int WINDOW_DEPTH = lzssd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  lzssd_pkg::t_cmd                 i_cmd,
    output lzssd_pkg::t_emit_status         o_status,
    output logic                            o_ram_we,
    output logic [$clog2(WINDOW_DEPTH)-1:0] o_ram_waddr,
    output logic [lzssd_pkg::BYTE_W-1:0]    o_ram_wdata,
    output logic                            o_ram_re,
    output logic [$clog2(WINDOW_DEPTH)-1:0] o_ram_raddr,
    input  logic [lzssd_pkg::BYTE_W-1:0]    i_ram_rdata,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [lzssd_pkg::BYTE_W-1:0]    o_byte,
    output logic                            o_kind,
    output logic                            o_ok,
    output logic                            o_last
);
    import lzssd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int DW = AW + 1;

    logic [LEN_W-1:0]  r_rem;
    logic [DW-1:0]     r_dist;
    logic [CNT_W-1:0]  r_rd_cnt;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_sum;
    logic              r_b_valid;
    logic              r_b_kind;
    logic              r_b_lit;
    logic              r_b_space;
    logic              r_b_fwd;
    logic [BYTE_W-1:0] r_b_data;
    logic              r_b_ok;
    logic              r_b_last;
    logic [BYTE_W-1:0] r_prev;
    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_kind;
    logic              r_o_ok;
    logic              r_o_last;

    logic              b_adv;
    logic              a_fire;
    logic              b_data_beat;
    logic [CNT_W-1:0]  rd_pos;
    logic              a_space;
    logic [BYTE_W-1:0] b_val;
    logic [DW-1:0]     cmd_dist;
    logic [CNT_W-1:0]  cnt_base;
    logic              idle;

    assign b_adv       = r_b_valid && (!r_o_valid || i_ready);
    assign a_fire      = (r_rem != '0) && (!r_b_valid || b_adv);
    assign rd_pos      = r_rd_cnt - CNT_W'(r_dist);
    assign a_space     = r_rd_cnt < CNT_W'(r_dist);
    assign b_data_beat = b_adv && !r_b_kind;
    assign idle        = (r_rem == '0) && !r_b_valid;
    assign cmd_dist    = (i_cmd.distance == '0) ? DW'(WINDOW_DEPTH) : DW'(i_cmd.distance);
    assign cnt_base    = i_cmd.clear ? '0 : r_cnt;

    // distance one reads the byte being written this cycle
    always_comb begin
        if (r_b_lit) begin
            b_val = r_b_data;
        end else if (r_b_space) begin
            b_val = SPACE_BYTE;
        end else if (r_b_fwd) begin
            b_val = r_prev;
        end else begin
            b_val = i_ram_rdata;
        end
    end

    assign o_ram_we    = b_data_beat;
    assign o_ram_waddr = r_cnt[AW-1:0];
    assign o_ram_wdata = b_val;
    assign o_ram_re    = a_fire;
    assign o_ram_raddr = rd_pos[AW-1:0];

    assign o_status.idle  = idle;
    assign o_status.count = r_cnt;
    assign o_status.sum   = r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= '0;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd_valid) begin
                if (i_cmd.clear) begin
                    r_cnt <= '0;
                    r_sum <= '0;
                end
                if (i_cmd.op == OP_RUN) begin
                    r_rem <= i_cmd.len;
                end
                if (i_cmd.op == OP_LIT || i_cmd.op == OP_VERDICT) begin
                    r_b_valid <= 1'b1;
                end
            end else begin
                if (a_fire) begin
                    r_rem     <= r_rem - 1'b1;
                    r_b_valid <= 1'b1;
                end else if (b_adv) begin
                    r_b_valid <= 1'b0;
                end
                if (b_data_beat) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_sum <= r_sum + CNT_W'(b_val);
                end
            end
            if (b_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_valid) begin
            r_rd_cnt <= cnt_base;
            r_dist   <= cmd_dist;
            r_b_kind <= (i_cmd.op == OP_VERDICT);
            r_b_lit  <= 1'b1;
            r_b_data <= i_cmd.data;
            r_b_ok   <= i_cmd.ok;
            r_b_last <= 1'b1;
        end else if (a_fire) begin
            r_rd_cnt  <= r_rd_cnt + 1'b1;
            r_b_kind  <= 1'b0;
            r_b_lit   <= 1'b0;
            r_b_space <= a_space;
            r_b_fwd   <= (r_dist == DW'(1));
            r_b_ok    <= 1'b0;
            r_b_last  <= (r_rem == LEN_W'(1));
        end
        if (b_data_beat) begin
            r_prev <= b_val;
        end
        if (b_adv) begin
            r_o_byte <= r_b_kind ? '0 : b_val;
            r_o_kind <= r_b_kind;
            r_o_ok   <= r_b_ok;
            r_o_last <= r_b_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_byte  = r_o_byte;
    assign o_kind  = r_o_kind;
    assign o_ok    = r_o_ok;
    assign o_last  = r_o_last;

    `LZSSD_ASSERT(a_cmd_when_idle, i_clk, i_rst_n,
        i_cmd_valid |-> idle,
        "command while run in flight")
    `LZSSD_ASSERT(a_issue_lead, i_clk, i_rst_n,
        (r_rem != '0) |-> ((r_rd_cnt - r_cnt) <= CNT_W'(1)),
        "read position ran ahead of writes")
    `LZSSD_ASSERT(a_last_at_end, i_clk, i_rst_n,
        (r_b_valid && r_b_last) |-> (r_rem == '0),
        "last marked with run bytes left")
endmodule

[hw/rtl/lzss_stream_decompressor_top.sv]
`timescale 1ns / 1ps
// LZSS decompressor, 4 KiB history. One compressed byte per input beat (tuser[0] starts a
// new stream); flag, pointer-low and non-final checksum bytes never hold the input off, but a
// literal or the final checksum byte holds the input off while its result passes a staging
// register. A pointer's high byte expands into a run of 3 to 18 bytes, produced one per
// cycle while the output accepts them, through the history RAM (one read port, one write
// port, registered read); the input holds off until the run has left the staging register.
// The output register lets the next input beat be taken while the last result waits.
// After reset the history is not cleared; positions before the stream start read as spaces.
module lzss_stream_decompressor_top #(
    parameter int WINDOW_DEPTH = lzssd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lzssd_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0]                    s_axis_tuser,   // [0] start_req
    input  logic                          i_cfg_wr_en,
    input  logic [lzssd_pkg::OLEN_W-1:0]  i_cfg_wr_data,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lzssd_pkg::BYTE_W-1:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]                    m_axis_tuser,   // [0] kind, [1] checksum_ok
    output logic                          m_axis_tlast
);
    import lzssd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    t_cmd              cmd;
    logic              cmd_valid;
    t_emit_status      status;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic              out_kind;
    logic              out_ok;

    lzssd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .i_start       (s_axis_tuser[0]),
        .i_status      (status),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd)
    );

    lzssd_emit #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_kind      (out_kind),
        .o_ok        (out_ok),
        .o_last      (m_axis_tlast)
    );

    lzssd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tuser = {out_ok, out_kind};
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
    import lzssd_pkg::*;

    localparam int WIN          = WINDOW_DEPTH_DEF;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 16;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              kind;
        logic              ok;
        logic              last;
    } t_dec_beat;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata  = '0;     // [7:0] in_byte
    logic [0:0]        s_axis_tuser  = '0;     // [0] start_req
    logic              i_cfg_wr_en   = 1'b0;
    logic [OLEN_W-1:0] i_cfg_wr_data = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [BYTE_W-1:0] m_axis_tdata;           // [7:0] out_byte
    logic [1:0]        m_axis_tuser;           // [0] kind, [1] checksum_ok
    logic              m_axis_tlast;

    lzss_stream_decompressor_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // decoder state mirror
    logic [7:0]        hist [WIN];
    logic [31:0]       produced;
    logic [31:0]       run_sum;
    logic [31:0]       sum_stored;
    logic [OLEN_W-1:0] out_len = '0;
    t_phase            phase_m;
    logic [7:0]        flag_byte;
    logic [7:0]        ptr_low;
    int                flag_idx;
    int                sum_seen;
    t_dec_beat         pending_q[$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_left     = 0;
    int quiet         = 0;
    int errors        = 0;
    int items_sent    = 0;
    int beats_checked = 0;
    int verdicts_seen = 0;

    function automatic void clear_stream_model();
        produced   = '0;
        phase_m    = PH_FLAG;
        flag_byte  = '0;
        flag_idx   = 0;
        ptr_low    = '0;
        run_sum    = '0;
        sum_stored = '0;
        sum_seen   = 0;
    endfunction

    function automatic t_dec_beat emit_data(logic [7:0] v);
        t_dec_beat r;
        hist[produced[11:0]] = v;
        produced++;
        run_sum += 32'(v);
        r = '{data: v, kind: 1'b0, ok: 1'b0, last: 1'b0};
        return r;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic start);
        t_dec_beat   outs[$];
        logic [31:0] idx;
        logic [7:0]  v;
        int          distance;
        int          len;
        if (start) clear_stream_model();
        if ((phase_m == PH_FLAG || phase_m == PH_PACKET) && produced >= 32'(out_len))
            phase_m = PH_SUM;
        case (phase_m)
            PH_FLAG: begin
                flag_byte = b;
                flag_idx  = 0;
                phase_m   = PH_PACKET;
            end
            PH_PACKET: begin
                if (flag_byte[flag_idx % 8]) begin
                    outs.push_back(emit_data(b));
                    flag_idx++;
                    if (flag_idx >= 8) phase_m = PH_FLAG;
                end else begin
                    ptr_low = b;
                    phase_m = PH_PTR_HIGH;
                end
            end
            PH_PTR_HIGH: begin
                distance = int'(ptr_low) + int'(b[7:4]) * 256;
                len      = int'(b[3:0]) + MIN_RUN;
                if (distance == 0) distance = WIN;
                for (int k = 0; k < len && k < MAX_RUN; k++) begin
                    if (produced < 32'(distance)) begin
                        v = SPACE_BYTE;
                    end else begin
                        idx = produced - 32'(distance);
                        v   = hist[idx[11:0]];
                    end
                    outs.push_back(emit_data(v));
                end
                flag_idx++;
                if (flag_idx >= 8) phase_m = PH_FLAG;
                else phase_m = PH_PACKET;
            end
            PH_SUM: begin
                sum_stored[8*sum_seen +: 8] = b;
                sum_seen++;
                if (sum_seen >= SUM_BYTES) begin
                    outs.push_back('{data: 8'h00, kind: 1'b1,
                                     ok: (sum_stored == run_sum), last: 1'b0});
                    phase_m = PH_DONE;
                end
            end
            default: ;
        endcase
        if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
        foreach (outs[i]) pending_q.push_back(outs[i]);
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        errors++;
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_dec_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_checked++;
            if (m_axis_tuser[0] === 1'b1) verdicts_seen++;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata, 8'h00);
            end else begin
                want = pending_q.pop_front();
                if (m_axis_tdata !== want.data)
                    report_mismatch("out_byte", m_axis_tdata, want.data);
                if (m_axis_tuser[0] !== want.kind)
                    report_mismatch("kind", 8'(m_axis_tuser[0]), 8'(want.kind));
                if (m_axis_tuser[1] !== want.ok)
                    report_mismatch("checksum_ok", 8'(m_axis_tuser[1]), 8'(want.ok));
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", 8'(m_axis_tlast), 8'(want.last));
            end
        end
        if (i_rst_n && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    // receiver: long hold-off on request, else random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // entered and left at a falling edge; tvalid stays high after the beat
    task automatic send_byte(logic [7:0] b, logic start);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid   = 1'b1;
        s_axis_tdata    = b;
        s_axis_tuser[0] = start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_byte(b, start);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic set_output_length(logic [OLEN_W-1:0] v);
        s_axis_tvalid = 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        out_len       = v;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    // well-formed stream steered by the mirrored decoder state
    task automatic play_stream(int max_items, logic [31:0] corrupt);
        int          n;
        int          distance;
        int          lim;
        logic [7:0]  b;
        logic [7:0]  ptr_high_next;
        logic [31:0] word;
        ptr_high_next = '0;
        clear_stream_model();
        for (n = 0; n < max_items && phase_m != PH_DONE; n++) begin
            if (phase_m == PH_SUM ||
                ((phase_m == PH_FLAG || phase_m == PH_PACKET) && produced >= 32'(out_len))) begin
                word = run_sum ^ corrupt;
                b    = word[8*sum_seen +: 8];
            end else if (phase_m == PH_FLAG) begin
                b = 8'($urandom);
            end else if (phase_m == PH_PACKET) begin
                if (flag_byte[flag_idx % 8]) begin
                    b = 8'($urandom);
                end else begin
                    lim = (produced > 32'd4095) ? 4095 : int'(produced);
                    if (lim < 1) lim = 1;
                    case ($urandom_range(9))
                        0:       distance = 0;
                        1, 2:    distance = $urandom_range(4095, 1);
                        default: distance = $urandom_range(lim, 1);
                    endcase
                    b             = distance[7:0];
                    ptr_high_next = {distance[11:8], 4'($urandom_range(15))};
                end
            end else begin
                b = ptr_high_next;
            end
            send_byte(b, n == 0);
        end
    endtask

    task automatic play_noise(int count);
        repeat (count) send_byte(8'($urandom), $urandom_range(9) == 0);
    endtask

    task automatic test_directed_stream();
        int k;
        set_output_length(31'd24);
        send_byte(8'h03, 1'b1);                              // two literals, then pointers
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h01, 1'b0); send_byte(8'h0f, 1'b0);      // dist 1, 18 bytes, overlapped
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);      // zero dist: 4096 back, spaces
        send_byte(8'hff, 1'b0); send_byte(8'hf0, 1'b0);      // dist 4095, before start; overshoot
        for (k = 0; k < SUM_BYTES; k++) send_byte(run_sum[8*k +: 8], 1'b0);
        send_byte(8'h5a, 1'b0);                              // after verdict: ignored
    endtask

    task automatic test_zero_length();
        set_output_length('0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);                              // bad checksum
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_unbounded_length();
        set_output_length({OLEN_W{1'b1}});
        send_byte(8'h02, 1'b1);
        send_byte(8'h10, 1'b0); send_byte(8'h2f, 1'b0);      // dist 0x210, all spaces
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0); send_byte(8'h00, 1'b0);
    endtask

    task automatic test_random_streams(int src_pct, int snk_pct);
        int          first_item;
        int          r;
        logic [31:0] corrupt;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        first_item    = items_sent;
        while (items_sent - first_item < PHASE_ITEMS) begin
            r = $urandom_range(99);
            if (r < 20)      set_output_length('0);
            else if (r < 90) set_output_length(OLEN_W'($urandom_range(60, 1)));
            else             set_output_length(OLEN_W'($urandom_range(250, 61)));
            corrupt = ($urandom_range(4) == 0) ? (32'd1 << $urandom_range(31)) : '0;
            if ($urandom_range(4) == 0) play_noise($urandom_range(12, 3));
            else play_stream($urandom_range(60, 10), corrupt);
        end
    endtask

    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        set_output_length(31'd100);
        hold_left = HOLD_CYCLES;
        play_stream(40, '0);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_stream();
        test_zero_length();
        test_unbounded_length();
        test_random_streams(0, 0);
        test_random_streams(52, 0);
        test_random_streams(0, 52);
        test_random_streams(15, 15);
        test_backpressure();

        s_axis_tvalid = 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d compressed bytes, %0d output beats incl. %0d checksum verdicts,",
                 items_sent, beats_checked, verdicts_seen);
        $display("over literal/pointer/overlap/pre-start/overshoot streams under idle and stall");
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/lzssd_pkg.sv
hw/rtl/lzssd_ram.sv
hw/rtl/lzssd_ctrl.sv
hw/rtl/lzssd_emit.sv
hw/rtl/lzss_stream_decompressor_top.sv
tb/tb.sv
